// File: design/mkd_pkg.sv
// Shared types, constants and letter code tables for the morse key decoder.
package mkd_pkg;

   localparam int LETTERS     = 26;
   localparam int MAX_SYMBOLS = 4;
   localparam int TICK_W      = 16;
   localparam int LETTER_W    = 5;
   localparam int COUNT_W     = 8;
   localparam int SYM_CNT_W   = 3;

   localparam logic [TICK_W-1:0] TICK_SAT        = '1;
   localparam logic [TICK_W-1:0] DOT_LIMIT_RST   = 16'd200;
   localparam logic [TICK_W-1:0] DASH_LIMIT_RST  = 16'd3000;
   localparam logic [TICK_W-1:0] GAP_LIMIT_RST   = 16'd1400;
   localparam logic [SYM_CNT_W-1:0] SYM_FULL     = SYM_CNT_W'(MAX_SYMBOLS);

   typedef enum logic [1:0] {
      KIND_LETTER  = 2'd0,
      KIND_UNKNOWN = 2'd1,
      KIND_ERASE   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_DOT_LIMIT  = 2'd0,
      CSR_DASH_LIMIT = 2'd1,
      CSR_GAP_LIMIT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                hit;
      logic [LETTER_W-1:0] letter;
   } match_type;

   typedef logic [SYM_CNT_W-1:0] code_len_type  [LETTERS];
   typedef logic [3:0]           code_bits_type [LETTERS];

   // symbol count per letter A..Z
   localparam code_len_type CODE_LEN = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   // dash mask per letter, bit i is symbol i
   localparam code_bits_type CODE_BITS = '{
      4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
      4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
   };

endpackage

// File: design/mkd_letter_match.sv
// Matches a collected dot/dash pattern against the letters A to Z.
module mkd_letter_match
   import mkd_pkg::*;
(
   input  logic [3:0]           symbol_bits,
   input  logic [SYM_CNT_W-1:0] symbol_count,
   output match_type            match
);

   always_comb begin
      match = '0;
      for (int i = 0; i < LETTERS; i++) begin
         if (CODE_LEN[i] == symbol_count && CODE_BITS[i] == symbol_bits) begin
            match.hit    = 1'b1;
            match.letter = match.letter | LETTER_W'(i);
         end
      end
   end

endmodule

// File: design/morse_key_decoder_core.sv
// A key sample waits in the input register; its result is then registered at rsp_tvalid.
// Throughput: one sample per cycle unless stalled; input and result registers run in step.
// A full result register with rsp_tready low stalls the input; req_tready follows it.
// Reset (synchronous, active high) clears timing and symbol state, the letter count,
// and loads the limit registers with their defaults.
module morse_key_decoder_core
   import mkd_pkg::*;
#(
   parameter int TEXT_LIMIT = 128
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] key_down
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] letter_index, [12:5] text_length
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [COUNT_W-1:0] TEXT_MAX = COUNT_W'(TEXT_LIMIT);

   logic [TICK_W-1:0]    dot_limit_ff, dash_limit_ff, gap_limit_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_key_ff;
   logic                 key_was_down_ff, key_was_down_in;
   logic [TICK_W-1:0]    press_ticks_ff, press_ticks_in;
   logic [TICK_W-1:0]    gap_ticks_ff, gap_ticks_in, gap_inc;
   logic [3:0]           symbol_bits_ff, symbol_bits_in;
   logic [SYM_CNT_W-1:0] symbol_count_ff, symbol_count_in;
   logic                 letter_pending_ff, letter_pending_in;
   logic [COUNT_W-1:0]   letter_count_ff, letter_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff, rsp_kind_in;
   logic [LETTER_W-1:0]  rsp_letter_ff, rsp_letter_in;
   logic [COUNT_W-1:0]   rsp_length_ff;
   logic                 advance, emit, dash;
   match_type            match;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !advance);

   mkd_letter_match u_match (
      .symbol_bits  (symbol_bits_ff),
      .symbol_count (symbol_count_ff),
      .match        (match)
   );

   assign gap_inc = (gap_ticks_ff < TICK_SAT) ? gap_ticks_ff + 1'b1 : gap_ticks_ff;
   assign dash    = !(press_ticks_ff < dot_limit_ff);

   always_comb begin
      key_was_down_in   = in_key_ff;
      press_ticks_in    = press_ticks_ff;
      gap_ticks_in      = gap_ticks_ff;
      symbol_bits_in    = symbol_bits_ff;
      symbol_count_in   = symbol_count_ff;
      letter_pending_in = letter_pending_ff;
      letter_count_in   = letter_count_ff;
      emit              = 1'b0;
      rsp_kind_in       = KIND_LETTER;
      rsp_letter_in     = '0;
      if (in_key_ff) begin
         if (!key_was_down_ff) begin
            press_ticks_in = TICK_W'(1);
         end else if (press_ticks_ff < TICK_SAT) begin
            press_ticks_in = press_ticks_ff + 1'b1;
         end
      end else if (key_was_down_ff) begin
         gap_ticks_in = '0;
         if (press_ticks_ff < dash_limit_ff) begin
            if (symbol_count_ff < SYM_FULL) begin
               symbol_bits_in  = symbol_bits_ff | ({3'b000, dash} << symbol_count_ff[1:0]);
               symbol_count_in = symbol_count_ff + 1'b1;
            end
            letter_pending_in = 1'b1;
         end else if (letter_count_ff != '0) begin
            letter_count_in = letter_count_ff - 1'b1;
            emit            = 1'b1;
            rsp_kind_in     = KIND_ERASE;
         end
      end else begin
         gap_ticks_in = gap_inc;
         if (letter_pending_ff && gap_inc > gap_limit_ff) begin
            emit = 1'b1;
            if (match.hit) begin
               rsp_kind_in   = KIND_LETTER;
               rsp_letter_in = match.letter;
               if (letter_count_ff < TEXT_MAX) begin
                  letter_count_in = letter_count_ff + 1'b1;
               end
            end else begin
               rsp_kind_in = KIND_UNKNOWN;
            end
            letter_pending_in = 1'b0;
            symbol_bits_in    = '0;
            symbol_count_in   = '0;
         end
      end
   end

   assign rsp_valid_in = advance ? emit : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_limit_ff  <= DOT_LIMIT_RST;
         dash_limit_ff <= DASH_LIMIT_RST;
         gap_limit_ff  <= GAP_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DOT_LIMIT:  dot_limit_ff  <= csr_data;
            CSR_DASH_LIMIT: dash_limit_ff <= csr_data;
            CSR_GAP_LIMIT:  gap_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         key_was_down_ff   <= 1'b0;
         press_ticks_ff    <= '0;
         gap_ticks_ff      <= '0;
         symbol_bits_ff    <= '0;
         symbol_count_ff   <= '0;
         letter_pending_ff <= 1'b0;
         letter_count_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            key_was_down_ff   <= key_was_down_in;
            press_ticks_ff    <= press_ticks_in;
            gap_ticks_ff      <= gap_ticks_in;
            symbol_bits_ff    <= symbol_bits_in;
            symbol_count_ff   <= symbol_count_in;
            letter_pending_ff <= letter_pending_in;
            letter_count_ff   <= letter_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_key_ff <= req_tdata[0];
      end
      if (advance && emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_letter_ff <= rsp_letter_in;
         rsp_length_ff <= letter_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'b000, rsp_length_ff, rsp_letter_ff};

   a_count_limit : assert property (@(posedge clock) disable iff (reset)
      letter_count_ff <= TEXT_MAX)
      else $error("letter count above text limit");

   a_symbols_pending : assert property (@(posedge clock) disable iff (reset)
      symbol_count_ff != '0 |-> letter_pending_ff)
      else $error("symbols held without a pending letter");

   a_decode_clears : assert property (@(posedge clock) disable iff (reset)
      advance && emit && rsp_kind_in != KIND_ERASE
      |=> symbol_count_ff == '0 && !letter_pending_ff)
      else $error("decode did not clear symbols");

   a_erase_length : assert property (@(posedge clock) disable iff (reset)
      advance && emit && rsp_kind_in == KIND_ERASE |=> letter_count_ff == rsp_length_ff)
      else $error("erase result length mismatch");

endmodule
